// ===== sv/sld_pkg.sv =====
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types, status codes and the crc-8 step for the sync/length deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sld_pkg;

  // result status codes
  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_CRC     = 2'd1;
  localparam logic [1:0] ST_LEN     = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  // sync byte after reset
  localparam logic [7:0] SYNC_RESET = 8'hAA;

  // crc-8, no reflection, no final xor
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // queue depths and count widths
  localparam int CQ_DEPTH = 2;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // frame outcome handed from the parser to the emitter
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] command;
    logic [7:0] count;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] command;
    logic [5:0] length;
    logic [7:0] data_byte;
    logic [4:0] byte_index;
    logic       last;
  } result_t;

  // one byte through the crc-8 register, msb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sld_ram.sv =====
// ----------------------------------------------------------------------------
// sld_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/sld_fifo.sv =====
// ----------------------------------------------------------------------------
// sld_fifo
// Small register fifo with occupancy count, used for the command and result queues.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty,
  output logic                  full,
  output logic      [CW-1:0]    count
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(DEPTH));
  assign count    = count_r;
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sld_front.sv =====
// ----------------------------------------------------------------------------
// sld_front
// Frame parser: hunts for sync, reads length, command, payload and crc, stores
// the payload and hands one outcome per finished or abandoned frame to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_front
  import sld_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32,
  parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_sync_value,
  input  wire logic          beat,
  input  wire logic          func,
  input  wire logic [7:0]    rx_byte,
  output logic               in_payload,
  output logic               cq_push,
  output cmd_t               cq_data,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [7:0]         ram_wdata
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_CMD  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRC  = 3'd4;

  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] sync_r;
  logic [7:0] length_r, length_nxt;
  logic [7:0] command_r, command_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [5:0] seen_r, seen_nxt;
  logic [5:0] seen_inc;
  logic [7:0] crc_step;

  assign in_payload = (phase_r == PH_DATA);
  assign seen_inc   = seen_r + 6'd1;
  assign crc_step   = crc8_update((phase_r == PH_CMD) ? CRC_INIT : crc_r, rx_byte);
  assign ram_waddr  = AW'(seen_r);
  assign ram_wdata  = rx_byte;

  // parser sequencing
  always_comb begin
    phase_nxt   = phase_r;
    length_nxt  = length_r;
    command_nxt = command_r;
    crc_nxt     = crc_r;
    seen_nxt    = seen_r;
    cq_push     = 1'b0;
    cq_data     = '{status: ST_GOOD, command: 8'd0, count: 8'd0};
    ram_we      = 1'b0;
    if (beat) begin
      if (func) begin
        cq_push        = 1'b1;
        cq_data.status = ST_TIMEOUT;
        phase_nxt      = PH_HUNT;
      end else begin
        unique case (phase_r)
          PH_HUNT: begin
            if (rx_byte == sync_r) begin
              phase_nxt = PH_LEN;
            end
          end
          PH_LEN: begin
            length_nxt = rx_byte;
            phase_nxt  = PH_CMD;
          end
          PH_CMD: begin
            command_nxt = rx_byte;
            if (length_r > MAX_LEN) begin
              cq_push        = 1'b1;
              cq_data.status = ST_LEN;
              phase_nxt      = PH_HUNT;
            end else begin
              crc_nxt   = crc_step;
              seen_nxt  = 6'd0;
              phase_nxt = (length_r == 8'd0) ? PH_CRC : PH_DATA;
            end
          end
          PH_DATA: begin
            ram_we   = ({2'b00, seen_r} < MAX_LEN);
            crc_nxt  = crc_step;
            seen_nxt = seen_inc;
            if ({2'b00, seen_inc} >= length_r) begin
              phase_nxt = PH_CRC;
            end
          end
          PH_CRC: begin
            cq_push   = 1'b1;
            phase_nxt = PH_HUNT;
            if (rx_byte != crc_r) begin
              cq_data.status = ST_CRC;
            end else begin
              cq_data.command = command_r;
              cq_data.count   = length_r;
            end
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      sync_r    <= SYNC_RESET;
      length_r  <= 8'd0;
      command_r <= 8'd0;
      crc_r     <= 8'd0;
      seen_r    <= 6'd0;
    end else begin
      phase_r   <= phase_nxt;
      length_r  <= length_nxt;
      command_r <= command_nxt;
      crc_r     <= crc_nxt;
      seen_r    <= seen_nxt;
      if (cfg_we) begin
        sync_r <= cfg_sync_value;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/sld_back.sv =====
// ----------------------------------------------------------------------------
// sld_back
// Result emitter: takes frame outcomes from the queue, pushes result beats to the
// output queue and reads the buffered payload a byte a cycle while it has room.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_back
  import sld_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32,
  parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cq_empty,
  input  wire cmd_t             cq_data,
  output logic                  cq_pop,
  output logic                  ram_re,
  output logic [AW-1:0]         ram_raddr,
  input  wire logic [7:0]       ram_rdata,
  input  wire logic [OQ_CW-1:0] oq_count,
  output logic                  oq_push,
  output result_t               oq_data,
  output logic                  busy
);

  logic       run_r, run_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] n_r, n_nxt;
  logic [7:0] k_r, k_nxt;
  logic       room;
  logic       run_last;

  // read stage: result fields waiting for the buffer read data
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_data_r, s1_data_nxt;
  result_t    s1_r, s1_nxt;

  // keep a slot free for the beat already in flight
  assign room      = (oq_count + OQ_CW'(s1_valid_r)) < OQ_CW'(OQ_DEPTH);
  assign run_last  = ((k_r + 8'd1) == n_r);
  assign ram_raddr = AW'(k_r);
  assign busy      = !cq_empty || run_r || s1_valid_r;

  // issue: one payload read per cycle during a run, else one outcome; both wait for room
  always_comb begin
    run_nxt      = run_r;
    cmd_nxt      = cmd_r;
    n_nxt        = n_r;
    k_nxt        = k_r;
    cq_pop       = 1'b0;
    ram_re       = 1'b0;
    s1_valid_nxt = 1'b0;
    s1_data_nxt  = 1'b0;
    s1_nxt       = s1_r;
    if (run_r) begin
      if (room) begin
        ram_re       = 1'b1;
        s1_valid_nxt = 1'b1;
        s1_data_nxt  = 1'b1;
        s1_nxt       = '{status: ST_GOOD, command: cmd_r, length: 6'(n_r),
                         data_byte: 8'd0, byte_index: 5'(k_r), last: run_last};
        k_nxt        = k_r + 8'd1;
        if (run_last) begin
          run_nxt = 1'b0;
        end
      end
    end else if (!cq_empty && room) begin
      cq_pop = 1'b1;
      if (cq_data.status == ST_GOOD && cq_data.count != 8'd0) begin
        run_nxt = 1'b1;
        cmd_nxt = cq_data.command;
        n_nxt   = cq_data.count;
        k_nxt   = 8'd0;
      end else begin
        s1_valid_nxt = 1'b1;
        s1_nxt       = '{status: cq_data.status, command: cq_data.command, length: 6'd0,
                         data_byte: 8'd0, byte_index: 5'd0, last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      run_r      <= run_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    n_r       <= n_nxt;
    k_r       <= k_nxt;
    s1_data_r <= s1_data_nxt;
    s1_r      <= s1_nxt;
  end

  // merge buffer data into the beat
  always_comb begin
    oq_push = s1_valid_r;
    oq_data = s1_r;
    if (s1_data_r) begin
      oq_data.data_byte = ram_rdata;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sync_length_crc8_deframer.sv =====
// ----------------------------------------------------------------------------
// sync_length_crc8_deframer
// Input beats are taken one a cycle while the outcome queue has room; a payload byte
// of the next frame waits while the emitter still holds an outcome or is reading out
// the previous payload. An error or empty-payload result passes the outcome queue
// and the emitter issue register; a payload run also passes the buffer read, then
// streams one beat a cycle with result queue room, set by the single buffer read port.
// Synchronous active-low reset returns to hunting with sync byte 0xAA; queues empty.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_crc8_deframer
  import sld_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_sync_value,
  input  wire logic       push,
  output logic            full,
  input  wire logic       in_func,
  input  wire logic [7:0] in_rx_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      out_status,
  output logic [7:0]      out_command,
  output logic [5:0]      out_length,
  output logic [7:0]      out_data_byte,
  output logic [4:0]      out_byte_index,
  output logic            out_last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CQ_W = $bits(cmd_t);
  localparam int OQ_W = $bits(result_t);

  logic             beat;
  logic             in_payload;
  logic             cq_push, cq_pop, cq_empty, cq_full;
  cmd_t             cq_wdata, cq_rdata;
  logic [$clog2(CQ_DEPTH + 1)-1:0] cq_count;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;
  logic             oq_push, oq_full;
  result_t          oq_wdata, oq_rdata;
  logic [OQ_CW-1:0] oq_count;
  logic             back_busy;

  // input side: hold off beats on a full outcome queue, payload bytes on a busy emitter
  assign cfg_ready = 1'b1;
  assign full      = cq_full || (in_payload && back_busy);
  assign beat      = push && !full;

  sld_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_sync_value (cfg_sync_value),
    .beat           (beat),
    .func           (in_func),
    .rx_byte        (in_rx_byte),
    .in_payload     (in_payload),
    .cq_push        (cq_push),
    .cq_data        (cq_wdata),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata)
  );

  // frame outcome queue between parser and emitter
  sld_fifo #(
    .WIDTH (CQ_W),
    .DEPTH (CQ_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cq_push),
    .push_data (cq_wdata),
    .pop       (cq_pop),
    .pop_data  (cq_rdata),
    .empty     (cq_empty),
    .full      (cq_full),
    .count     (cq_count)
  );

  // payload buffer
  sld_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_payload_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  sld_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cq_empty  (cq_empty),
    .cq_data   (cq_rdata),
    .cq_pop    (cq_pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .oq_count  (oq_count),
    .oq_push   (oq_push),
    .oq_data   (oq_wdata),
    .busy      (back_busy)
  );

  // result queue
  sld_fifo #(
    .WIDTH (OQ_W),
    .DEPTH (OQ_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (oq_push),
    .push_data (oq_wdata),
    .pop       (pop),
    .pop_data  (oq_rdata),
    .empty     (empty),
    .full      (oq_full),
    .count     (oq_count)
  );

  assign out_status     = oq_rdata.status;
  assign out_command    = oq_rdata.command;
  assign out_length     = oq_rdata.length;
  assign out_data_byte  = oq_rdata.data_byte;
  assign out_byte_index = oq_rdata.byte_index;
  assign out_last       = oq_rdata.last;

  // payload buffer is never rewritten while a run may still read it
  a_no_write_during_run: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !back_busy)
    else $error("payload buffer written while emitter busy");

  // emitter reservation keeps the result queue from overflowing
  a_out_q_room: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> !oq_full)
    else $error("result beat pushed into full queue");

  // parser only produces an outcome when the queue has room
  a_cmd_q_room: assert property (@(posedge clk) disable iff (!rst_n)
    cq_push |-> (cq_count != 2'(CQ_DEPTH)))
    else $error("frame outcome pushed into full queue");

  // a buffer read always turns into a result beat on the next cycle
  a_read_to_beat: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> oq_push)
    else $error("buffer read without result beat");

endmodule

`default_nettype wire
